[rtl/ssat_pkg.sv]
// Package for the sorted sparse accumulator table: commands, status codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none
package ssat_pkg;
	localparam int CAPACITY_DEF = 1024;

	typedef enum logic [1:0] {
		CMD_SET  = 2'd0,
		CMD_ACC  = 2'd1,
		CMD_LOOK = 2'd2,
		CMD_PRUNE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_MERGED   = 3'd1,
		ST_FOUND    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4,
		ST_PRUNED   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_HIT_RD,
		S_HIT_CMP,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PRUNE_RD,
		S_PRUNE_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;        // capture the input transaction
		logic srch_init;   // lo = 0, hi = count
		logic srch_rd;     // read at mid
		logic srch_step;   // narrow the interval
		logic hit_rd;      // read at lo
		logic hit_lat;     // latch hit flag
		logic merge_wr;    // write merged value at lo
		logic shift_init;  // idx = count
		logic shift_rd;    // read at idx - 1
		logic shift_wr;    // write to idx, idx--
		logic ins_wr;      // write new entry at lo, count++
		logic prune_init;  // r = w = 0
		logic prune_rd;    // read at r
		logic prune_wr;    // conditional write at w, advance
		logic prune_end;   // count = w
		logic res_full;    // result: table full
		logic res_look;    // result: lookup
		logic res_merge;   // result: merged
		logic res_ins;     // result: inserted
		logic res_prune;   // result: pruned
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       srch_done; // lo == hi
		logic       hit;
		logic       full;
		logic       shift_done; // idx == lo
		logic       prune_done; // r == count
	} sts_t;
endpackage
`default_nettype wire

[rtl/ssat_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ssat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

[rtl/ssat_ctrl.sv]
// Controller state machine of the sorted sparse accumulator table.
// Depends on ssat_pkg.
`default_nettype none
module ssat_ctrl import ssat_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_fire,
	input  wire sts_t sts,
	output ctl_t      ctl,
	output logic      busy,
	output logic      res_valid
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = (cmd_t'(sts.cmd) == CMD_PRUNE) ? S_PRUNE_RD
				: S_SRCH_RD;
			S_SRCH_RD:  state_d = sts.srch_done ? S_HIT_RD : S_SRCH_CMP;
			S_SRCH_CMP: state_d = S_SRCH_RD;
			S_HIT_RD:   state_d = S_HIT_CMP;
			S_HIT_CMP:  state_d = S_DECIDE;
			S_DECIDE: begin
				if (cmd_t'(sts.cmd) == CMD_LOOK || sts.hit || sts.full) state_d = S_DONE;
				else state_d = sts.shift_done ? S_DONE : S_SHIFT_RD;
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			// return to decide once the last entry has moved; it then inserts
			S_SHIFT_WR: state_d = sts.shift_done ? S_DECIDE : S_SHIFT_RD;
			S_PRUNE_RD: state_d = sts.prune_done ? S_DONE : S_PRUNE_WR;
			S_PRUNE_WR: state_d = S_PRUNE_RD;
			S_DONE:     if (out_fire) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				ctl.load = in_fire;
				ctl.srch_init = in_fire;
				ctl.prune_init = in_fire;
			end
			S_SRCH_RD: begin
				ctl.srch_rd = !sts.srch_done;
				ctl.hit_rd = sts.srch_done;
			end
			S_SRCH_CMP: ctl.srch_step = 1'b1;
			S_HIT_RD: ctl.hit_rd = 1'b1;
			S_HIT_CMP: begin
				ctl.hit_lat = 1'b1;
				ctl.shift_init = 1'b1;
			end
			S_DECIDE: begin
				if (cmd_t'(sts.cmd) == CMD_LOOK) ctl.res_look = 1'b1;
				else if (sts.hit) begin
					ctl.merge_wr = 1'b1;
					ctl.res_merge = 1'b1;
				end else if (sts.full) ctl.res_full = 1'b1;
				else if (sts.shift_done) begin
					ctl.ins_wr = 1'b1;
					ctl.res_ins = 1'b1;
				end
			end
			S_SHIFT_RD: ctl.shift_rd = 1'b1;
			S_SHIFT_WR: ctl.shift_wr = 1'b1;
			S_PRUNE_RD: begin
				ctl.prune_rd = !sts.prune_done;
				ctl.prune_end = sts.prune_done;
				ctl.res_prune = sts.prune_done;
			end
			S_PRUNE_WR: ctl.prune_wr = 1'b1;
			S_DONE: ;
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);

	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_fire) |=> state_q == S_IDLE)
		else $error("done state did not return to idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> state_q == S_IDLE)
		else $error("load outside idle");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({ctl.merge_wr, ctl.ins_wr, ctl.prune_wr, ctl.shift_wr}) <= 1)
		else $error("conflicting table writes");
endmodule
`default_nettype wire

[rtl/ssat_dp.sv]
// Datapath of the sorted sparse accumulator table: id/value RAMs, search,
// shift and compaction pointers, result registers. Depends on ssat_pkg, ssat_ram.
`default_nettype none
module ssat_dp import ssat_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctl_t                ctl,
	output sts_t                     sts,
	input  wire logic [1:0]          cmd,
	input  wire logic [31:0]         key_id,
	input  wire logic signed [31:0]  in_value,
	input  wire logic signed [31:0]  prune_low,
	input  wire logic signed [31:0]  prune_high,
	output logic [2:0]               status,
	output logic signed [31:0]       out_value,
	output logic [9:0]               position,
	output logic [10:0]              entry_count
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [1:0]         cmd_q;
	logic [31:0]        key_q;
	logic signed [31:0] val_q;
	logic [CW-1:0]      count_q, lo_q, hi_q, idx_q, w_q;
	logic               hit_q;
	logic [CW-1:0]      mid;
	logic [AW-1:0]      addr;
	logic               we;
	logic [31:0]        id_wd, id_rd;
	logic signed [31:0] v_wd, v_rd;
	logic signed [32:0] sum;
	logic signed [31:0] sat, merged;
	logic               keep;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign sum = {v_rd[31], v_rd} + {val_q[31], val_q};
	assign sat = (sum[32] != sum[31]) ? {sum[32], {31{~sum[32]}}} : sum[31:0];
	assign merged = (cmd_t'(cmd_q) == CMD_ACC) ? sat : val_q;
	assign keep = !(v_rd < prune_low || v_rd > prune_high);

	always_comb begin
		addr = lo_q[AW-1:0];
		we = 1'b0;
		id_wd = id_rd;
		v_wd = v_rd;
		priority if (ctl.srch_rd) addr = mid[AW-1:0];
		else if (ctl.shift_rd) addr = AW'(idx_q - 1'b1);
		else if (ctl.prune_rd) addr = idx_q[AW-1:0];
		else if (ctl.shift_wr) begin
			addr = idx_q[AW-1:0];
			we = 1'b1;
		end else if (ctl.prune_wr) begin
			addr = w_q[AW-1:0];
			we = keep;
		end else if (ctl.merge_wr) begin
			we = 1'b1;
			v_wd = merged;
			id_wd = key_q;
		end else if (ctl.ins_wr) begin
			we = 1'b1;
			id_wd = key_q;
			v_wd = val_q;
		end else if (ctl.hit_rd) addr = lo_q[AW-1:0];
	end

	// shifting moves one entry up per read/write pair; the insert at lo
	// follows in its own cycle once idx has walked down to lo
	ssat_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ids (
		.clk(clk), .we(we), .addr(addr), .wdata(id_wd), .rdata(id_rd));
	ssat_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_vals (
		.clk(clk), .we(we), .addr(addr), .wdata(v_wd), .rdata(v_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (ctl.hit_lat) hit_q <= (lo_q < count_q) && (id_rd == key_q);
			if (ctl.ins_wr) count_q <= count_q + 1'b1;
			if (ctl.prune_end) count_q <= w_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			key_q <= key_id;
			val_q <= in_value;
		end
		if (ctl.srch_init) begin
			lo_q <= '0;
			hi_q <= count_q;
		end
		if (ctl.srch_step) begin
			if (id_rd < key_q) lo_q <= mid + 1'b1;
			else hi_q <= mid;
		end
		if (ctl.shift_init) idx_q <= count_q;
		if (ctl.shift_wr) idx_q <= idx_q - 1'b1;
		if (ctl.prune_init) begin
			idx_q <= '0;
			w_q <= '0;
		end
		if (ctl.prune_wr) begin
			idx_q <= idx_q + 1'b1;
			if (keep) w_q <= w_q + 1'b1;
		end
		if (ctl.res_full || ctl.res_look || ctl.res_merge || ctl.res_ins || ctl.res_prune) begin
			out_value <= '0;
			position <= '0;
			priority if (ctl.res_full) status <= ST_FULL;
			else if (ctl.res_prune) status <= ST_PRUNED;
			else if (ctl.res_look) begin
				status <= hit_q ? ST_FOUND : ST_NOTFOUND;
				if (hit_q) begin
					out_value <= v_rd;
					position <= 10'(lo_q);
				end
			end else begin
				status <= ctl.res_merge ? ST_MERGED : ST_INSERTED;
				out_value <= ctl.res_merge ? merged : val_q;
				position <= 10'(lo_q);
			end
		end
	end

	// entry_count reflects the count register, already final by S_DONE
	assign entry_count = 11'(count_q);

	assign sts.cmd = ctl.load ? cmd : cmd_q;
	assign sts.srch_done = (lo_q == hi_q);
	assign sts.hit = hit_q;
	assign sts.full = (count_q >= CW'(CAPACITY));
	assign sts.shift_done = ctl.shift_wr ? ((idx_q - 1'b1) == lo_q) : (idx_q == lo_q);
	assign sts.prune_done = (idx_q == count_q);

	a_lo_le_hi: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.srch_step |=> lo_q <= hi_q)
		else $error("search interval inverted");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count above capacity");
	a_prune_w: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.prune_wr |-> w_q <= idx_q)
		else $error("compaction write pointer ahead of read");
endmodule
`default_nettype wire

[rtl/sorted_sparse_accumulator_table.sv]
// Sorted sparse accumulator table: top level, config registers and handshake.
// Depends on ssat_pkg, ssat_ctrl, ssat_dp, ssat_ram.
// Search is a binary search over the sorted ids; an insert first shifts the entries
// above the insert point up by one, and prune compacts the table in place.
// One transaction at a time, set by the single-port table RAMs. Reset: async active
// low clears count and the controller and restores the full-range prune bounds.
`default_nettype none
module sorted_sparse_accumulator_table import ssat_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic [31:0]        key_id,
	input  wire logic signed [31:0] in_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic signed [31:0]      out_value,
	output logic [9:0]              position,
	output logic [10:0]             entry_count,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [31:0]        cfg_wdata
);
	localparam logic REG_LOW = 1'b0;

	logic signed [31:0] prune_low_q, prune_high_q;
	ctl_t ctl;
	sts_t sts;
	logic busy, in_fire, out_fire;

	// hold the prune bounds; a write with index 0 is low, 1 is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prune_low_q <= 32'sh8000_0000;
			prune_high_q <= 32'sh7fff_ffff;
		end else if (cfg_we) begin
			if (cfg_index == REG_LOW) prune_low_q <= cfg_wdata;
			else prune_high_q <= cfg_wdata;
		end
	end

	assign in_ready = !busy;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	ssat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .ctl(ctl), .busy(busy), .res_valid(out_valid));

	ssat_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.cmd(cmd), .key_id(key_id), .in_value(in_value),
		.prune_low(prune_low_q), .prune_high(prune_high_q),
		.status(status), .out_value(out_value), .position(position),
		.entry_count(entry_count));

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");
	a_result_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !out_valid)
		else $error("result appeared with no work");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(status))
		else $error("result dropped under stall");
endmodule
`default_nettype wire
